### design/nppc_pkg.sv
`timescale 1ns / 1ps

package nppc_pkg;

  // field widths fixed by the interface
  localparam int CHAN_W  = 8;
  localparam int COLOR_W = 3 * CHAN_W;
  localparam int SQ_W    = 2 * CHAN_W;
  localparam int LIMIT_W = 18;
  localparam int INDEX_W = 8;
  localparam int COUNT_W = 9;
  localparam int FUNC_W  = 2;

  // limit after reset: 64*64*3
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64 * 64 * 3);

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

endpackage

### design/nppc_palette.sv
`timescale 1ns / 1ps

module nppc_palette #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic [nppc_pkg::COLOR_W-1:0] wdata,
  input  logic                         re,
  input  logic [AW-1:0]                raddr,
  output logic [nppc_pkg::COLOR_W-1:0] rdata
);

  logic [nppc_pkg::COLOR_W-1:0] mem [DEPTH];

  // single write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/nppc_dist.sv
`timescale 1ns / 1ps

module nppc_dist #(
  parameter int IDX_W = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [IDX_W-1:0]             in_idx,
  input  logic [nppc_pkg::CHAN_W-1:0]  q_red,
  input  logic [nppc_pkg::CHAN_W-1:0]  q_green,
  input  logic [nppc_pkg::CHAN_W-1:0]  q_blue,
  input  logic [nppc_pkg::COLOR_W-1:0] entry,
  output logic                         out_valid,
  output logic [IDX_W-1:0]             out_idx,
  output logic [nppc_pkg::LIMIT_W-1:0] out_sum
);

  localparam int CW = nppc_pkg::CHAN_W;
  localparam int SW = nppc_pkg::SQ_W;
  localparam int LW = nppc_pkg::LIMIT_W;

  logic [CW-1:0] e_red, e_green, e_blue;
  logic [CW-1:0] d_red, d_green, d_blue;
  logic [SW-1:0] sq_red, sq_green, sq_blue;

  // absolute channel differences
  always_comb begin
    e_red   = entry[3*CW-1:2*CW];
    e_green = entry[2*CW-1:CW];
    e_blue  = entry[CW-1:0];
    d_red   = (q_red   > e_red)   ? (q_red   - e_red)   : (e_red   - q_red);
    d_green = (q_green > e_green) ? (q_green - e_green) : (e_green - q_green);
    d_blue  = (q_blue  > e_blue)  ? (q_blue  - e_blue)  : (e_blue  - q_blue);
  end

  // squares registered before the sum
  always_ff @(posedge clk) begin
    sq_red   <= d_red * d_red;
    sq_green <= d_green * d_green;
    sq_blue  <= d_blue * d_blue;
    out_idx  <= in_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  // three-term sum, fits in the limit width
  assign out_sum = LW'(sq_red) + LW'(sq_green) + LW'(sq_blue);

endmodule

### design/nearest_palette_color_match.sv
`timescale 1ns / 1ps

// channel   | ports                                          | handshake
// ----------+------------------------------------------------+---------------------------
// request   | func, red, green, blue                         | start high, busy low
// result    | found, match_index, match_distance, status,    | done high for one cycle
//           | entry_count                                    |
// config    | max_distance_wdata                             | max_distance_we high
//
// for clear, append and unused codes the result shows in the cycle after they are accepted.
// a query holds busy until its scan has drained, also on an empty palette:
// one palette read per cycle feeds the single distance unit via the read and square registers.
// the result of a query shows in the same cycle that busy falls.
// rst is synchronous: palette count 0, limit 12288, no result pending.
// results cannot be stalled; done is a one-cycle strobe.

module nearest_palette_color_match #(
  parameter int ENTRIES = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [nppc_pkg::FUNC_W-1:0]  func,
  input  logic [nppc_pkg::CHAN_W-1:0]  red,
  input  logic [nppc_pkg::CHAN_W-1:0]  green,
  input  logic [nppc_pkg::CHAN_W-1:0]  blue,
  input  logic                         max_distance_we,
  input  logic [nppc_pkg::LIMIT_W-1:0] max_distance_wdata,
  output logic                         done,
  output logic                         found,
  output logic [nppc_pkg::INDEX_W-1:0] match_index,
  output logic [nppc_pkg::LIMIT_W-1:0] match_distance,
  output logic                         status,
  output logic [nppc_pkg::COUNT_W-1:0] entry_count
);

  localparam int CW = $clog2(ENTRIES + 1);
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int LW = nppc_pkg::LIMIT_W;
  localparam int IW = nppc_pkg::INDEX_W;
  localparam int NW = nppc_pkg::COUNT_W;
  localparam int HW = nppc_pkg::CHAN_W;

  nppc_pkg::state_t state, state_next;

  logic [LW-1:0] limit;
  logic [CW-1:0] count;
  logic [CW-1:0] scan_idx;
  logic [HW-1:0] q_red, q_green, q_blue;
  logic [LW-1:0] best;
  logic [AW-1:0] best_idx;
  logic          best_found;
  logic          rd_valid;
  logic [AW-1:0] rd_idx;
  logic          sq_valid;
  logic [AW-1:0] sq_idx;
  logic [LW-1:0] sq_sum;
  logic [nppc_pkg::COLOR_W-1:0] rd_data;

  logic accept, do_append, full, issue, drained;
  logic [CW+NW-1:0] count_ext;
  logic [AW+IW-1:0] idx_ext;

  assign busy      = (state == nppc_pkg::ST_SCAN);
  assign accept    = start && !busy;
  assign full      = (count >= CW'(ENTRIES));
  assign do_append = accept && (func == nppc_pkg::FUNC_APPEND) && !full;
  assign issue     = busy && (scan_idx < count);
  assign drained   = busy && !issue && !rd_valid && !sq_valid;
  assign count_ext = {{NW{1'b0}}, count};
  assign idx_ext   = {{IW{1'b0}}, best_idx};

  // limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= nppc_pkg::LIMIT_RESET;
    end else if (max_distance_we) begin
      limit <= max_distance_wdata;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      nppc_pkg::ST_IDLE: begin
        if (accept && func == nppc_pkg::FUNC_QUERY) begin
          state_next = nppc_pkg::ST_SCAN;
        end
      end
      nppc_pkg::ST_SCAN: begin
        if (drained) begin
          state_next = nppc_pkg::ST_IDLE;
        end
      end
      default: state_next = nppc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nppc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept && func == nppc_pkg::FUNC_CLEAR) begin
      count <= '0;
    end else if (do_append) begin
      count <= count + CW'(1);
    end
  end

  // query color and scan address
  always_ff @(posedge clk) begin
    if (accept) begin
      q_red    <= red;
      q_green  <= green;
      q_blue   <= blue;
      scan_idx <= '0;
    end else if (issue) begin
      scan_idx <= scan_idx + CW'(1);
    end
  end

  // read stage tag
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= scan_idx[AW-1:0];
  end

  nppc_palette #(
    .DEPTH (ENTRIES),
    .AW    (AW)
  ) u_palette (
    .clk   (clk),
    .we    (do_append),
    .waddr (count[AW-1:0]),
    .wdata ({red, green, blue}),
    .re    (issue),
    .raddr (scan_idx[AW-1:0]),
    .rdata (rd_data)
  );

  nppc_dist #(
    .IDX_W (AW)
  ) u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rd_valid),
    .in_idx    (rd_idx),
    .q_red     (q_red),
    .q_green   (q_green),
    .q_blue    (q_blue),
    .entry     (rd_data),
    .out_valid (sq_valid),
    .out_idx   (sq_idx),
    .out_sum   (sq_sum)
  );

  // running minimum, strict compare keeps the earliest entry on a tie
  always_ff @(posedge clk) begin
    if (rst) begin
      best_found <= 1'b0;
    end else if (accept) begin
      best_found <= 1'b0;
    end else if (sq_valid && sq_sum < best) begin
      best_found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      best <= limit;
    end else if (sq_valid && sq_sum < best) begin
      best     <= sq_sum;
      best_idx <= sq_idx;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (accept && func != nppc_pkg::FUNC_QUERY) || drained;
    end
  end

  // result fields
  always_ff @(posedge clk) begin
    if (rst) begin
      found          <= 1'b0;
      match_index    <= '0;
      match_distance <= '0;
      status         <= 1'b0;
      entry_count    <= '0;
    end else if (drained) begin
      found          <= best_found;
      match_index    <= best_found ? idx_ext[IW-1:0] : '0;
      match_distance <= best_found ? best : '0;
      status         <= 1'b0;
      entry_count    <= count_ext[NW-1:0];
    end else if (accept && func != nppc_pkg::FUNC_QUERY) begin
      found          <= 1'b0;
      match_index    <= '0;
      match_distance <= '0;
      status         <= (func == nppc_pkg::FUNC_APPEND) && full;
      if (func == nppc_pkg::FUNC_CLEAR) begin
        entry_count <= '0;
      end else if (do_append) begin
        entry_count <= NW'(count_ext + (CW + NW)'(1));
      end else begin
        entry_count <= count_ext[NW-1:0];
      end
    end
  end

  // checks
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    accept && func == nppc_pkg::FUNC_QUERY |=> busy)
    else $error("query accepted but scan not started");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && !found |-> match_index == '0 && match_distance == '0)
    else $error("miss result carries nonzero index or distance");

  a_hit_below: assert property (@(posedge clk) disable iff (rst)
    done && found |-> match_distance < limit)
    else $error("match distance not below limit");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(ENTRIES))
    else $error("entry count beyond palette depth");

  a_pipe_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_valid || sq_valid |-> busy)
    else $error("distance pipeline active outside a query");

endmodule

### dv/palette_match_checker.sv
`timescale 1ns / 1ps

module palette_match_checker #(
  parameter int ENTRIES = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         busy,
  input  logic [nppc_pkg::FUNC_W-1:0]  func,
  input  logic [nppc_pkg::CHAN_W-1:0]  red,
  input  logic [nppc_pkg::CHAN_W-1:0]  green,
  input  logic [nppc_pkg::CHAN_W-1:0]  blue,
  input  logic                         max_distance_we,
  input  logic [nppc_pkg::LIMIT_W-1:0] max_distance_wdata,
  input  logic                         done,
  input  logic                         found,
  input  logic [nppc_pkg::INDEX_W-1:0] match_index,
  input  logic [nppc_pkg::LIMIT_W-1:0] match_distance,
  input  logic                         status,
  input  logic [nppc_pkg::COUNT_W-1:0] entry_count,
  output int                           failures,
  output int                           pending
);

  import nppc_pkg::*;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] index;
    logic [LIMIT_W-1:0] distance;
    logic               status;
    logic [COUNT_W-1:0] count;
  } match_result_t;

  // shadow of the palette, its fill level and the match limit
  logic [COLOR_W-1:0] shadow_palette [ENTRIES];
  int                 shadow_count;
  logic [LIMIT_W-1:0] shadow_limit;

  match_result_t      expected_q [$];

  // squared difference of one channel, widened to the distance width
  function automatic logic [LIMIT_W-1:0] chan_sq(logic [CHAN_W-1:0] a,
                                                 logic [CHAN_W-1:0] b);
    logic [LIMIT_W-1:0] d;
    d = (a > b) ? LIMIT_W'(a - b) : LIMIT_W'(b - a);
    return d * d;
  endfunction

  // apply one request to the shadow state and work out its result
  function automatic match_result_t predict_match(logic [FUNC_W-1:0] op,
                                                  logic [CHAN_W-1:0] r,
                                                  logic [CHAN_W-1:0] g,
                                                  logic [CHAN_W-1:0] b);
    match_result_t      res;
    logic [LIMIT_W-1:0] best;
    logic [LIMIT_W-1:0] sum_sq;
    res  = '0;
    best = shadow_limit;
    case (op)
      FUNC_CLEAR: begin
        shadow_count = 0;
      end
      FUNC_APPEND: begin
        if (shadow_count < ENTRIES) begin
          shadow_palette[shadow_count] = {r, g, b};
          shadow_count++;
        end else begin
          res.status = 1'b1;
        end
      end
      FUNC_QUERY: begin
        // strict compare keeps the earliest entry on a tie
        for (int i = 0; i < shadow_count; i++) begin
          sum_sq = chan_sq(r, shadow_palette[i][23:16]) + chan_sq(g, shadow_palette[i][15:8])
                 + chan_sq(b, shadow_palette[i][7:0]);
          if (sum_sq < best) begin
            best      = sum_sq;
            res.index = INDEX_W'(i);
            res.found = 1'b1;
          end
        end
        if (res.found) begin
          res.distance = best;
        end
      end
      default: begin
        // unused code leaves everything alone
      end
    endcase
    res.count = COUNT_W'(shadow_count);
    return res;
  endfunction

  // sample both channels at the rising edge
  always @(posedge clk) begin
    match_result_t want;
    match_result_t got;
    if (rst) begin
      shadow_count = 0;
      shadow_limit = LIMIT_RESET;
      expected_q.delete();
    end else begin
      // results leave first: a new request never completes in its own cycle
      if (done) begin
        got = '{found, match_index, match_distance, status, entry_count};
        if (expected_q.size() == 0) begin
          failures++;
          if (failures <= 10) begin
            $display("%0t: result with no request waiting: found=%0d index=%0d",
                     $realtime, got.found, got.index);
            $display("%0t:          distance=%0d status=%0d count=%0d",
                     $realtime, got.distance, got.status, got.count);
          end
        end else begin
          want = expected_q.pop_front();
          if (got.found !== want.found || got.index !== want.index ||
              got.distance !== want.distance || got.status !== want.status ||
              got.count !== want.count) begin
            failures++;
            if (failures <= 10) begin
              $display("%0t: mismatch expected found=%0d index=%0d distance=%0d %s%0d%s%0d",
                       $realtime, want.found, want.index, want.distance,
                       "status=", want.status, " count=", want.count);
              $display("%0t:          actual   found=%0d index=%0d distance=%0d %s%0d%s%0d",
                       $realtime, got.found, got.index, got.distance,
                       "status=", got.status, " count=", got.count);
            end
          end
        end
      end
      // a request accepted at this edge still sees the old limit
      if (start && !busy) begin
        expected_q.push_back(predict_match(func, red, green, blue));
      end
      if (max_distance_we) begin
        shadow_limit = max_distance_wdata;
      end
    end
    pending = expected_q.size();
  end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  import nppc_pkg::*;

  localparam logic [FUNC_W-1:0]  FUNC_UNUSED  = 2'd3;
  localparam int                 PALETTE_SIZE = 256;
  localparam int                 REQUESTS     = 2000;
  localparam logic [LIMIT_W-1:0] LIMIT_TOP    = LIMIT_W'(195076);

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [FUNC_W-1:0]  func;
  logic [CHAN_W-1:0]  red;
  logic [CHAN_W-1:0]  green;
  logic [CHAN_W-1:0]  blue;
  logic               max_distance_we;
  logic [LIMIT_W-1:0] max_distance_wdata;
  logic               done;
  logic               found;
  logic [INDEX_W-1:0] match_index;
  logic [LIMIT_W-1:0] match_distance;
  logic               status;
  logic [COUNT_W-1:0] entry_count;
  int                 failures;
  int                 pending;

  // colors appended since the last clear, used to aim queries near entries
  logic [COLOR_W-1:0] appended_q [$];
  int                 requests_sent;
  int                 fills_done;
  int                 next_limit_change;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  nearest_palette_color_match #(
    .ENTRIES(PALETTE_SIZE)
  ) uut (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .func              (func),
    .red               (red),
    .green             (green),
    .blue              (blue),
    .max_distance_we   (max_distance_we),
    .max_distance_wdata(max_distance_wdata),
    .done              (done),
    .found             (found),
    .match_index       (match_index),
    .match_distance    (match_distance),
    .status            (status),
    .entry_count       (entry_count)
  );

  palette_match_checker #(
    .ENTRIES(PALETTE_SIZE)
  ) chk (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .func              (func),
    .red               (red),
    .green             (green),
    .blue              (blue),
    .max_distance_we   (max_distance_we),
    .max_distance_wdata(max_distance_wdata),
    .done              (done),
    .found             (found),
    .match_index       (match_index),
    .match_distance    (match_distance),
    .status            (status),
    .entry_count       (entry_count),
    .failures          (failures),
    .pending           (pending)
  );

  // issue one request after a random gap; returns at the falling edge after acceptance
  task automatic send(logic [FUNC_W-1:0] op, logic [CHAN_W-1:0] r,
                      logic [CHAN_W-1:0] g, logic [CHAN_W-1:0] b);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    func  = op;
    red   = r;
    green = g;
    blue  = b;
    do @(posedge clk); while (busy);
    @(negedge clk);
    case (op)
      FUNC_CLEAR:  appended_q.delete();
      FUNC_APPEND: if (appended_q.size() < PALETTE_SIZE) appended_q.push_back({r, g, b});
      default:     ;
    endcase
    if (op != FUNC_UNUSED) begin
      requests_sent++;
    end
  endtask

  task automatic append_random();
    send(FUNC_APPEND, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  function automatic logic [CHAN_W-1:0] jitter(logic [CHAN_W-1:0] c, int spread);
    int v;
    v = int'(c) + $urandom_range(0, 2 * spread) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return CHAN_W'(v);
  endfunction

  // query close to a stored color, sometimes far off or fully random
  task automatic query_near();
    logic [COLOR_W-1:0] pick;
    int                 spread;
    if (appended_q.size() == 0 || $urandom_range(0, 4) == 0) begin
      send(FUNC_QUERY, 8'($urandom), 8'($urandom), 8'($urandom));
    end else begin
      pick   = appended_q[$urandom_range(0, appended_q.size() - 1)];
      spread = ($urandom_range(0, 3) == 0) ? 70 : $urandom_range(0, 10);
      send(FUNC_QUERY, jitter(pick[23:16], spread), jitter(pick[15:8], spread),
           jitter(pick[7:0], spread));
    end
  endtask

  // limit changes only once every result is back
  task automatic write_limit(logic [LIMIT_W-1:0] value);
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    max_distance_we    = 1'b1;
    max_distance_wdata = value;
    @(negedge clk);
    max_distance_we    = 1'b0;
  endtask

  function automatic logic [LIMIT_W-1:0] pick_limit();
    case ($urandom_range(0, 5))
      0:       return LIMIT_RESET;
      1:       return '0;
      2:       return LIMIT_TOP;
      3:       return LIMIT_W'($urandom_range(0, LIMIT_TOP));
      4:       return LIMIT_W'($urandom_range(1, 3000));
      default: return LIMIT_W'($urandom_range(65536, 131071));
    endcase
  endfunction

  // fill the palette to the top, try a few dropped appends, then query it
  task automatic fill_palette();
    send(FUNC_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom));
    while (appended_q.size() < PALETTE_SIZE) append_random();
    repeat ($urandom_range(1, 3)) append_random();
    repeat (8) query_near();
    fills_done++;
  endtask

  // clear (usually), a few appends, then mostly queries
  task automatic short_palette();
    if ($urandom_range(0, 2) != 0) begin
      send(FUNC_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom));
    end
    repeat ($urandom_range(1, 12)) append_random();
    repeat ($urandom_range(2, 10)) begin
      if ($urandom_range(0, 4) == 0) begin
        append_random();
      end else begin
        query_near();
      end
    end
  endtask

  // stimulus
  initial begin
    rst                = 1'b1;
    start              = 1'b0;
    func               = FUNC_CLEAR;
    red                = '0;
    green              = '0;
    blue               = '0;
    max_distance_we    = 1'b0;
    max_distance_wdata = '0;
    requests_sent      = 0;
    fills_done         = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty palette and the unused code
    send(FUNC_QUERY, 8'd0, 8'd0, 8'd0);
    send(FUNC_UNUSED, 8'd255, 8'd255, 8'd255);
    // corners and a three-way tie
    send(FUNC_APPEND, 8'd0, 8'd0, 8'd0);
    send(FUNC_APPEND, 8'd255, 8'd255, 8'd255);
    send(FUNC_APPEND, 8'd40, 8'd0, 8'd0);
    send(FUNC_APPEND, 8'd0, 8'd40, 8'd0);
    send(FUNC_QUERY, 8'd0, 8'd0, 8'd0);
    send(FUNC_QUERY, 8'd255, 8'd255, 8'd255);
    send(FUNC_QUERY, 8'd20, 8'd20, 8'd0);
    send(FUNC_QUERY, 8'd128, 8'd128, 8'd128);
    send(FUNC_QUERY, 8'd40, 8'd10, 8'd0);
    send(FUNC_APPEND, 8'd170, 8'd85, 8'd170);
    send(FUNC_APPEND, 8'd85, 8'd170, 8'd85);
    send(FUNC_QUERY, 8'd170, 8'd85, 8'd171);
    // zero limit never matches
    write_limit('0);
    send(FUNC_QUERY, 8'd0, 8'd0, 8'd0);
    // widest limit, largest distance just below it and then equal to it
    write_limit(LIMIT_TOP);
    send(FUNC_QUERY, 8'd128, 8'd128, 8'd128);
    send(FUNC_CLEAR, 8'd255, 8'd255, 8'd255);
    send(FUNC_APPEND, 8'd0, 8'd0, 8'd0);
    send(FUNC_QUERY, 8'd255, 8'd255, 8'd255);
    write_limit(LIMIT_TOP - 1);
    send(FUNC_QUERY, 8'd255, 8'd255, 8'd255);
    // empty again after a clear
    send(FUNC_CLEAR, 8'd0, 8'd0, 8'd0);
    send(FUNC_QUERY, 8'd10, 8'd10, 8'd10);
    send(FUNC_UNUSED, 8'd0, 8'd0, 8'd0);
    write_limit(LIMIT_RESET);

    // random requests, limit moved every couple of hundred requests
    fill_palette();
    next_limit_change = requests_sent + 200;
    while (requests_sent < REQUESTS) begin
      if (requests_sent >= next_limit_change) begin
        write_limit(pick_limit());
        next_limit_change = requests_sent + 200;
      end
      case ($urandom_range(0, 9))
        0: begin
          repeat ($urandom_range(1, 6)) begin
            send(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), 8'($urandom));
          end
        end
        1: begin
          if (fills_done < 2) begin
            fill_palette();
          end else begin
            short_palette();
          end
        end
        default: short_palette();
      endcase
    end

    // drain
    start = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // hang guard
  initial begin
    #40_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
